>>> rtl/mcro_pkg.sv
package mcro_pkg;

  // Largest cursor the row store holds.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = $clog2(MAX_HEIGHT);
  // Signed working width for coordinates: covers -2 .. 128 and the store limits.
  localparam int CoordW = 10;

  localparam logic signed [CoordW-1:0] MAX_W_C = CoordW'(MAX_WIDTH);
  localparam logic signed [CoordW-1:0] MAX_H_C = CoordW'(MAX_HEIGHT);

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [7:0] BYTE_FULL = 8'hff;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic       and_bit;
    logic       xor_bit;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       outlined;
  } out_t;

  // One pixel write into the row store.
  typedef struct packed {
    logic            en;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            opaque;
    logic            white;
  } wr_t;

  // Three-row window fetch: rows above, at and below the center.
  typedef struct packed {
    logic                 en;
    logic [2:0][RowW-1:0] addr;
    logic [2:0]           in_range;
  } rd_t;

  typedef struct packed {
    logic [2:0][MAX_WIDTH-1:0] opq;
    logic [MAX_WIDTH-1:0]      wht;
    logic [2:0]                row_ok;
  } win_t;

endpackage

>>> rtl/mcro_ram.sv
module mcro_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mcro_store.sv
module mcro_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  mcro_pkg::wr_t wr_i,
  input  mcro_pkg::rd_t rd_i,
  output mcro_pkg::win_t win_o
);
  import mcro_pkg::*;

  logic [MAX_HEIGHT-1:0] row_valid_q, row_valid_d;
  logic [2:0]            row_ok_q;
  logic [MAX_WIDTH-1:0]  bit_sel;
  logic [MAX_WIDTH-1:0]  wmask;
  logic [MAX_WIDTH-1:0]  opq_wdata;
  logic [MAX_WIDTH-1:0]  wht_wdata;
  logic [2:0][MAX_WIDTH-1:0] opq_rdata;
  logic [MAX_WIDTH-1:0]  wht_rdata;

  // A row not written since the last clear gets its whole word rewritten.
  assign bit_sel   = MAX_WIDTH'(1) << wr_i.col;
  assign wmask     = row_valid_q[wr_i.row] ? bit_sel : '1;
  assign opq_wdata = wr_i.opaque ? bit_sel : '0;
  assign wht_wdata = wr_i.white ? bit_sel : '0;

  always_comb begin
    row_valid_d = row_valid_q;
    if (clear_i) begin
      row_valid_d = '0;
    end else if (wr_i.en) begin
      row_valid_d[wr_i.row] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else begin
      row_valid_q <= row_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      for (int k = 0; k < 3; k++) begin
        row_ok_q[k] <= rd_i.in_range[k] && row_valid_q[rd_i.addr[k]];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_opq
    mcro_ram #(
      .WIDTH(MAX_WIDTH),
      .DEPTH(MAX_HEIGHT)
    ) u_opq_ram (
      .clk_i  (clk_i),
      .we_i   (wr_i.en),
      .waddr_i(wr_i.row),
      .wdata_i(opq_wdata),
      .wmask_i(wmask),
      .re_i   (rd_i.en),
      .raddr_i(rd_i.addr[k]),
      .rdata_o(opq_rdata[k])
    );
  end

  mcro_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_wht_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i.en),
    .waddr_i(wr_i.row),
    .wdata_i(wht_wdata),
    .wmask_i(wmask),
    .re_i   (rd_i.en),
    .raddr_i(rd_i.addr[1]),
    .rdata_o(wht_rdata)
  );

  assign win_o.opq    = opq_rdata;
  assign win_o.wht    = wht_rdata;
  assign win_o.row_ok = row_ok_q;

endmodule

>>> rtl/mcro_pixel.sv
module mcro_pixel (
  input  logic                                  flag_i,
  input  logic                                  in_image_i,
  input  logic signed [mcro_pkg::CoordW-1:0]    cx_i,
  input  logic signed [mcro_pkg::CoordW-1:0]    eff_w_i,
  input  mcro_pkg::win_t                        win_i,
  output mcro_pkg::out_t                        pix_o
);
  import mcro_pkg::*;

  logic signed [CoordW-1:0] col [3];
  logic [2:0]               col_ok;
  logic [2:0][2:0]          hit;
  logic                     center_on;
  logic                     center_white;
  logic [7:0]               rgb;
  logic [7:0]               alpha;

  assign col[0] = cx_i - CoordW'(1);
  assign col[1] = cx_i;
  assign col[2] = cx_i + CoordW'(1);

  always_comb begin
    for (int dx = 0; dx < 3; dx++) begin
      col_ok[dx] = (col[dx] >= 0) && (col[dx] < eff_w_i);
    end
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        hit[dy][dx] = win_i.row_ok[dy] && col_ok[dx] &&
                      win_i.opq[dy][col[dx][ColW-1:0]];
      end
    end
  end

  assign center_on    = hit[1][1];
  assign center_white = win_i.wht[col[1][ColW-1:0]];

  always_comb begin
    rgb   = '0;
    alpha = '0;
    if (in_image_i) begin
      if (center_on) begin
        alpha = BYTE_FULL;
        rgb   = center_white ? BYTE_FULL : '0;
      end else if (flag_i && (|hit)) begin
        // outline: a transparent spot next to a visible pixel
        alpha = BYTE_FULL;
        rgb   = BYTE_FULL;
      end
    end
  end

  assign pix_o.red      = rgb;
  assign pix_o.green    = rgb;
  assign pix_o.blue     = rgb;
  assign pix_o.alpha    = alpha;
  assign pix_o.outlined = flag_i;

endmodule

>>> rtl/mono_cursor_to_rgba_outline_unit.sv
// Reads go through fetch, then into the result register when it is free or being emptied.
// One beat per cycle of any kind unless in_stall_o is high; only read beats give output.
// Rate is set by the row store: three opaque-row ports and one white-row port per beat.
// Reset: width and height return to 32, outline flag clears, row valid bits clear.
// Row memories are not cleared; a row reads as transparent until written after reset/begin.
module mono_cursor_to_rgba_outline_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mcro_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mcro_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [6:0]     cfg_wdata_i
);
  import mcro_pkg::*;

  // Configuration registers
  logic [6:0] cfg_width_q;
  logic [6:0] cfg_height_q;

  // Outline flag
  logic flag_q, flag_d;

  // Fetch stage: row data sits in the store's read registers
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_flag_q;
  logic                     s1_in_image_q;
  logic signed [CoordW-1:0] s1_cx_q;

  // Result register
  logic out_valid_q, out_valid_d;
  out_t out_q;

  logic                     in_acc;
  logic                     out_ready;
  logic                     is_begin, is_load, is_read;
  logic signed [CoordW-1:0] eff_w, eff_h;
  logic signed [CoordW-1:0] px, py;
  logic signed [CoordW-1:0] cx, cy;
  logic signed [CoordW-1:0] row_c [3];
  logic                     load_in_bounds;
  logic                     in_image;
  wr_t                      wr;
  rd_t                      rd;
  win_t                     win;
  out_t                     pix;

  // ---------------------------------------------------------------------------
  // Handshake: the fetch stage advances whenever the result register is free
  // or being emptied; hold the input only when a read sits stuck in fetch.
  // ---------------------------------------------------------------------------
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_begin = in_acc && (in_data_i.operation == OP_BEGIN);
  assign is_load  = in_acc && (in_data_i.operation == OP_LOAD);
  assign is_read  = in_acc && (in_data_i.operation == OP_READ);

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 7'd32;
      cfg_height_q <= 7'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        CFG_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clip the programmed size to what the store holds.
  always_comb begin
    eff_w = $signed(CoordW'(cfg_width_q));
    eff_h = $signed(CoordW'(cfg_height_q));
    if (eff_w > MAX_W_C) begin
      eff_w = MAX_W_C;
    end
    if (eff_h > MAX_H_C) begin
      eff_h = MAX_H_C;
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinates. With the outline on, the image grows by two and the cursor
  // shifts one pixel right and down.
  // ---------------------------------------------------------------------------
  assign px = $signed(CoordW'(in_data_i.pos_x));
  assign py = $signed(CoordW'(in_data_i.pos_y));
  assign cx = flag_q ? px - CoordW'(1) : px;
  assign cy = flag_q ? py - CoordW'(1) : py;

  always_comb begin
    if (flag_q) begin
      in_image = (px < eff_w + CoordW'(2)) && (py < eff_h + CoordW'(2));
    end else begin
      in_image = (px < eff_w) && (py < eff_h);
    end
  end

  assign row_c[0] = cy - CoordW'(1);
  assign row_c[1] = cy;
  assign row_c[2] = cy + CoordW'(1);

  always_comb begin
    rd.en = is_read;
    for (int k = 0; k < 3; k++) begin
      rd.addr[k]     = row_c[k][RowW-1:0];
      rd.in_range[k] = (row_c[k] >= 0) && (row_c[k] < eff_h);
    end
  end

  // ---------------------------------------------------------------------------
  // Load: write the opaque and white bits straight from the input beat.
  // ---------------------------------------------------------------------------
  assign load_in_bounds = (px < eff_w) && (py < eff_h);

  always_comb begin
    wr.en     = is_load && load_in_bounds;
    wr.row    = py[RowW-1:0];
    wr.col    = px[ColW-1:0];
    wr.opaque = !in_data_i.and_bit || in_data_i.xor_bit;
    wr.white  = !in_data_i.and_bit && in_data_i.xor_bit;
  end

  always_comb begin
    flag_d = flag_q;
    if (is_begin) begin
      flag_d = 1'b0;
    end else if (wr.en && in_data_i.and_bit && in_data_i.xor_bit) begin
      flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  mcro_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(is_begin),
    .wr_i   (wr),
    .rd_i   (rd),
    .win_o  (win)
  );

  // ---------------------------------------------------------------------------
  // Fetch stage: only read beats enter; advance into the result register.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (is_read) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_flag_q     <= flag_q;
      s1_in_image_q <= in_image;
      s1_cx_q       <= cx;
    end
  end

  mcro_pixel u_pixel (
    .flag_i    (s1_flag_q),
    .in_image_i(s1_in_image_q),
    .cx_i      (s1_cx_q),
    .eff_w_i   (eff_w),
    .win_i     (win),
    .pix_o     (pix)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A waiting read moves into a free result register.
  a_fetch_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_ready |=> out_valid_q)
    else $error("fetched read did not reach the result register");

  // A begin beat drops the outline flag.
  a_begin_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_begin |=> !flag_q)
    else $error("outline flag survived a begin beat");

  // A read enters fetch carrying the flag seen at acceptance.
  a_read_enters_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> s1_valid_q && (s1_flag_q == $past(flag_q)))
    else $error("read beat lost or flag mismatch in fetch stage");
`endif

endmodule

>>> sim/tb_top.sv
module tb_top;
  import mcro_pkg::*;

  // Unused operation code: the block must swallow it without a result.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // A read beat reaches the output through the fetch stage and the result register; give it some slack.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BEATS = 250;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_beat   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_beat;
  logic       cfg_we    = 1'b0;
  logic       cfg_idx   = CFG_WIDTH;
  logic [6:0] cfg_wdata = '0;

  // Idle rates in percent, and a long receiver hold-off counted in cycles.
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int stall_cycles_left = 0;
  int mismatches        = 0;

  // Shadow copy of the cursor store, the outline flag and both size registers.
  bit [MAX_WIDTH-1:0] opq_rows [MAX_HEIGHT];
  bit [MAX_WIDTH-1:0] wht_rows [MAX_HEIGHT];
  bit                 outline_on = 1'b0;
  logic [6:0]         cur_w      = 7'd32;
  logic [6:0]         cur_h      = 7'd32;

  // Pixels the block owes us, oldest first.
  out_t pending_pixels [$];

  mono_cursor_to_rgba_outline_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    opq_rows = '{default: '0};
    wht_rows = '{default: '0};
  end

  // Receiver: either sit out a requested hold-off or stall at random.
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      out_stall <= 1'b1;
      stall_cycles_left = stall_cycles_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int eff_w();
    return (int'(cur_w) > MAX_WIDTH) ? MAX_WIDTH : int'(cur_w);
  endfunction

  function automatic int eff_h();
    return (int'(cur_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_h);
  endfunction

  // Look up one stored bit; anything off the cursor reads as clear.
  function automatic bit cell_at(input bit want_white, input int x, input int y);
    if (x < 0 || y < 0 || x >= eff_w() || y >= eff_h()) return 1'b0;
    return want_white ? wht_rows[y][x] : opq_rows[y][x];
  endfunction

  // Work out the RGBA pixel a read beat at output position (x,y) must return.
  function automatic out_t render_pixel(input int x, input int y);
    out_t px;
    int   cx, cy, dx, dy;
    bit   in_img;
    px          = '0;
    px.outlined = outline_on;
    if (outline_on) begin
      // Outlined image is two larger and the cursor sits one pixel in.
      in_img = (x < eff_w() + 2) && (y < eff_h() + 2);
      cx     = x - 1;
      cy     = y - 1;
    end else begin
      in_img = (x < eff_w()) && (y < eff_h());
      cx     = x;
      cy     = y;
    end
    if (in_img) begin
      if (cell_at(1'b0, cx, cy)) begin
        px.alpha = BYTE_FULL;
        if (cell_at(1'b1, cx, cy)) begin
          px.red   = BYTE_FULL;
          px.green = BYTE_FULL;
          px.blue  = BYTE_FULL;
        end
      end else if (outline_on) begin
        // Transparent spot next to any visible pixel turns into white border.
        for (dy = -1; dy <= 1; dy++) begin
          for (dx = -1; dx <= 1; dx++) begin
            if (cell_at(1'b0, cx + dx, cy + dy)) begin
              px.red   = BYTE_FULL;
              px.green = BYTE_FULL;
              px.blue  = BYTE_FULL;
              px.alpha = BYTE_FULL;
            end
          end
        end
      end
    end
    return px;
  endfunction

  // Advance the shadow state by one accepted input beat.
  task automatic apply_beat(input in_t b);
    int x, y;
    x = int'(b.pos_x);
    y = int'(b.pos_y);
    case (b.operation)
      OP_BEGIN: begin
        opq_rows   = '{default: '0};
        wht_rows   = '{default: '0};
        outline_on = 1'b0;
      end
      OP_LOAD: begin
        // Drop loads that fall outside the effective cursor, flag included.
        if (x < eff_w() && y < eff_h()) begin
          if (!b.and_bit) begin
            opq_rows[y][x] = 1'b1;
            wht_rows[y][x] = b.xor_bit;
          end else if (b.xor_bit) begin
            // Inverted pixel: draw it black and ask for the outline.
            opq_rows[y][x] = 1'b1;
            wht_rows[y][x] = 1'b0;
            outline_on     = 1'b1;
          end else begin
            opq_rows[y][x] = 1'b0;
            wht_rows[y][x] = 1'b0;
          end
        end
      end
      OP_READ: pending_pixels = {pending_pixels, render_pixel(x, y)};
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compare every output beat against the oldest owed pixel.
  always @(posedge clk) begin : check_pixels
    out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("output beat with no read outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (out_beat !== want)
          report_mismatch($sformatf(
            "pixel got r%0h g%0h b%0h a%0h o%0b, want r%0h g%0h b%0h a%0h o%0b",
            out_beat.red, out_beat.green, out_beat.blue, out_beat.alpha,
            out_beat.outlined, want.red, want.green, want.blue, want.alpha,
            want.outlined));
      end
    end
  end

  function automatic in_t make_beat(input logic [1:0] op, input int x, input int y,
                                    input int a, input int xb);
    in_t b;
    b.operation = op;
    b.pos_x     = 7'(x);
    b.pos_y     = 7'(y);
    b.and_bit   = a[0];
    b.xor_bit   = xb[0];
    return b;
  endfunction

  // Offer one beat from a falling edge, idling first at the sender's rate.
  // Leave valid high on return; the next call or a drain decides what follows.
  task automatic send_beat(input in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_beat(b);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed pixel, then let the pipeline empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= 7'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) cur_w = 7'(value);
    else                  cur_h = 7'(value);
    @(negedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // One cursor: set the size, begin, then a random mix of loads and reads
  // with some noise: spare opcodes, out-of-range loads and the odd re-begin.
  task automatic run_frame(input int w_reg, input int h_reg, input int n_items,
                           inout int counted);
    int w, h, x, y, pick, enc, a, xb, i;
    bit allow_outline;
    drain_results();
    write_reg(CFG_WIDTH, w_reg);
    write_reg(CFG_HEIGHT, h_reg);
    send_beat(make_beat(OP_BEGIN, $urandom_range(127), $urandom_range(127),
                        $urandom_range(1), $urandom_range(1)));
    w = eff_w();
    h = eff_h();
    allow_outline = 1'($urandom_range(1));
    i = 1;
    while (i < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        x   = (w > 0) ? $urandom_range(w - 1) : $urandom_range(127);
        y   = (h > 0) ? $urandom_range(h - 1) : $urandom_range(127);
        enc = $urandom_range(9);
        if (enc < 5) begin
          a  = 0;
          xb = $urandom_range(1);
        end else if (enc < 8 || !allow_outline) begin
          a  = 1;
          xb = 0;
        end else begin
          a  = 1;
          xb = 1;
        end
        send_beat(make_beat(OP_LOAD, x, y, a, xb));
        if (w > 0 && h > 0) i++;
      end else if (pick < 88) begin
        // Mostly inside the image and its border; now and then anywhere.
        if ($urandom_range(9) == 0) begin
          x = $urandom_range(127);
          y = $urandom_range(127);
        end else begin
          x = $urandom_range(w + 2);
          y = $urandom_range(h + 2);
        end
        send_beat(make_beat(OP_READ, x, y, $urandom_range(1), $urandom_range(1)));
        i++;
      end else if (pick < 94) begin
        send_beat(make_beat(OP_SPARE, $urandom_range(127), $urandom_range(127),
                            $urandom_range(1), $urandom_range(1)));
      end else if (pick < 98) begin
        send_beat(make_beat(OP_LOAD, $urandom_range(127, w), $urandom_range(127),
                            $urandom_range(1), $urandom_range(1)));
      end else begin
        send_beat(make_beat(OP_BEGIN, $urandom_range(127), $urandom_range(127),
                            $urandom_range(1), $urandom_range(1)));
        i++;
      end
    end
    counted += i;
  endtask

  // Every operation, every load encoding, both image shapes and the edges.
  task automatic test_directed_ops();
    set_idle(24, 64);
    // Reset sizes are 32 by 32.
    send_beat(make_beat(OP_BEGIN, 0, 0, 0, 0));
    send_beat(make_beat(OP_LOAD, 31, 31, 0, 1));
    send_beat(make_beat(OP_READ, 31, 31, 0, 0));
    send_beat(make_beat(OP_READ, 32, 0, 0, 0));
    drain_results();
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 2);
    send_beat(make_beat(OP_BEGIN, 127, 127, 1, 1));
    send_beat(make_beat(OP_LOAD, 0, 0, 0, 1));   // opaque white
    send_beat(make_beat(OP_LOAD, 2, 1, 0, 0));   // opaque black
    send_beat(make_beat(OP_LOAD, 1, 0, 1, 0));   // transparent
    send_beat(make_beat(OP_LOAD, 3, 0, 1, 1));   // past the width: flag must hold
    send_beat(make_beat(OP_LOAD, 0, 2, 0, 1));   // past the height
    send_beat(make_beat(OP_READ, 0, 0, 0, 0));
    send_beat(make_beat(OP_READ, 2, 1, 0, 0));
    send_beat(make_beat(OP_READ, 1, 0, 0, 0));
    send_beat(make_beat(OP_READ, 1, 1, 0, 0));   // cleared by begin
    send_beat(make_beat(OP_READ, 3, 0, 0, 0));   // outside the image
    send_beat(make_beat(OP_READ, 127, 127, 1, 1));
    send_beat(make_beat(OP_SPARE, 127, 127, 1, 1));
    send_beat(make_beat(OP_LOAD, 1, 1, 1, 1));   // inverted: outline on
    send_beat(make_beat(OP_READ, 0, 0, 0, 0));   // border corner
    send_beat(make_beat(OP_READ, 1, 1, 0, 0));   // shifted white pixel
    send_beat(make_beat(OP_READ, 3, 2, 0, 0));   // shifted black pixel
    send_beat(make_beat(OP_READ, 4, 3, 0, 0));   // far border corner
    send_beat(make_beat(OP_READ, 2, 1, 0, 0));   // transparent pixel turns to border
    send_beat(make_beat(OP_READ, 5, 0, 0, 0));   // just past outlined width
    send_beat(make_beat(OP_READ, 0, 4, 0, 0));   // just past outlined height
    send_beat(make_beat(OP_LOAD, 1, 1, 0, 0));   // overwrite keeps the flag
    send_beat(make_beat(OP_READ, 2, 2, 0, 0));
    send_beat(make_beat(OP_BEGIN, 0, 0, 0, 0));
    send_beat(make_beat(OP_READ, 0, 0, 0, 0));
    drain_results();
  endtask

  // Size extremes: full store, oversized registers, empty and single pixel.
  task automatic test_size_extremes();
    int n;
    n = 0;
    set_idle(64, 24);
    run_frame(64, 64, 30, n);
    run_frame(127, 127, 20, n);
    run_frame(0, 0, 8, n);
    run_frame(1, 1, 15, n);
    run_frame(1, 64, 15, n);
    run_frame(64, 1, 15, n);
    run_frame(0, 127, 6, n);
    run_frame(65, 0, 6, n);
    drain_results();
  endtask

  // Hold the receiver off long enough to fill the block and stall the sender,
  // then pause the sender until every owed pixel is back.
  task automatic test_backpressure();
    int i;
    drain_results();
    write_reg(CFG_WIDTH, 6);
    write_reg(CFG_HEIGHT, 5);
    set_idle(0, 0);
    send_beat(make_beat(OP_BEGIN, 0, 0, 0, 0));
    for (i = 0; i < 12; i++)
      send_beat(make_beat(OP_LOAD, $urandom_range(5), $urandom_range(4),
                          $urandom_range(1), $urandom_range(1)));
    stall_cycles_left = 80;
    for (i = 0; i < 60; i++)
      send_beat(make_beat(OP_READ, $urandom_range(7), $urandom_range(6), 0, 0));
    drain_results();
    for (i = 0; i < 20; i++)
      send_beat(make_beat(OP_READ, $urandom_range(7), $urandom_range(6), 1, 1));
    drain_results();
  endtask

  // Random cursors, mostly small, walking through all three idle patterns.
  task automatic test_random_frames();
    int counted, r, w, h;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      if (counted < RANDOM_BEATS / 3)          set_idle(24, 64);
      else if (counted < 2 * RANDOM_BEATS / 3) set_idle(64, 24);
      else                                     set_idle(0, 0);
      r = $urandom_range(19);
      if (r < 14) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end else if (r < 16) begin
        w = $urandom_range(9, 20);
        h = $urandom_range(9, 20);
      end else if (r == 16) begin
        w = 64;
        h = 64;
      end else if (r == 17) begin
        w = $urandom_range(65, 127);
        h = $urandom_range(65, 127);
      end else if (r == 18) begin
        w = 0;
        h = $urandom_range(127);
      end else begin
        w = $urandom_range(127);
        h = $urandom_range(127);
      end
      run_frame(w, h, $urandom_range(12, 40), counted);
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_ops();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    // Catch any stray output beat after the last read.
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
